FILE: design/gvls_pkg.sv
// ----------------------------------------------------------------------------
// gvls_pkg
// Shared widths, constants and register codes of the 3D grid trellis
// layer step.
// ----------------------------------------------------------------------------
package gvls_pkg;

  localparam int PROB_W     = 16;
  localparam int LOG_W      = 16;
  localparam int COST_W     = 32;
  localparam int PRED_W     = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;
  localparam int START_W    = 4;
  localparam int REACH_W    = 3;
  localparam int SIZE_W     = 5;

  localparam int LOG_TABLE_BITS = 10;

  localparam logic [PROB_W-1:0] PROB_LO = 16'd66;
  localparam logic [PROB_W-1:0] PROB_HI = 16'd65470;
  localparam logic [31:0]       LN2_Q32 = 32'd2977044472;

  localparam logic signed [COST_W-1:0] UNREACH  = 32'sh8000_0000;
  localparam logic signed [COST_W-1:0] COST_MIN = 32'sh8000_0001;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH       = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH_Z_LOW = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z      = 4'd7;

endpackage

FILE: design/gvls_ln.sv
// ----------------------------------------------------------------------------
// gvls_ln
// Iterative natural log of a quantised occupancy probability in Q0.16, to
// signed Q4.12, by leading-one search, twenty squaring steps and ln 2 scaling.
// ----------------------------------------------------------------------------
module gvls_ln (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [gvls_pkg::PROB_W-1:0]         prob,
  output logic                                done,
  output logic signed [gvls_pkg::LOG_W-1:0]   log_val
);
  import gvls_pkg::*;

  localparam int SH        = PROB_W - LOG_TABLE_BITS;
  localparam int SQ_STEPS  = 20;
  localparam int FRAC_BITS = 20;

  localparam logic [PROB_W-1:0] LOW_MASK = PROB_W'((32'd1 << SH) - 32'd1);
  localparam logic [PROB_W-1:0] HALF     = PROB_W'((32'd1 << SH) >> 1);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_SQ   = 2'd1;
  localparam logic [1:0] L_MUL  = 2'd2;
  localparam logic [1:0] L_RND  = 2'd3;

  logic [1:0]              st_r;
  logic [4:0]              cnt_r;
  logic [30:0]             m_r;
  logic [3:0]              n_r;
  logic [FRAC_BITS-1:0]    frac_r;
  logic [55:0]             mag_r;
  logic                    done_r;
  logic signed [LOG_W-1:0] val_r;

  logic [PROB_W-1:0] c_map;
  logic [PROB_W-1:0] c_cl;
  logic [3:0]        lead;
  logic [30:0]       m_init;
  logic [61:0]       sq;
  logic [31:0]       t;
  logic [23:0]       l2n;
  logic [55:0]       prodm;
  logic [56:0]       rnd;

  always_comb begin
    c_map = (prob & ~LOW_MASK) | HALF;
    if (c_map < PROB_LO) begin
      c_cl = PROB_LO;
    end else if (c_map > PROB_HI) begin
      c_cl = PROB_HI;
    end else begin
      c_cl = c_map;
    end
    lead = '0;
    for (int i = 0; i < PROB_W; i++) begin
      if (c_cl[i]) begin
        lead = 4'(i);
      end
    end
    m_init = 31'(c_cl) << (5'd30 - 5'(lead));
    sq     = 62'(m_r) * 62'(m_r);
    t      = sq[61:30];
    l2n    = (24'(5'd16 - 5'(n_r)) << FRAC_BITS) - 24'(frac_r);
    prodm  = 56'(l2n) * 56'(LN2_Q32);
    rnd    = 57'(mag_r) + (57'd1 << 39);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      unique case (st_r)
        L_IDLE: begin
          if (start) begin
            m_r    <= m_init;
            n_r    <= lead;
            frac_r <= '0;
            cnt_r  <= '0;
            done_r <= 1'b0;
            st_r   <= L_SQ;
          end
        end
        L_SQ: begin
          m_r    <= t[31] ? t[31:1] : t[30:0];
          frac_r <= {frac_r[FRAC_BITS-2:0], t[31]};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'(SQ_STEPS - 1)) begin
            st_r <= L_MUL;
          end
        end
        L_MUL: begin
          mag_r <= prodm;
          st_r  <= L_RND;
        end
        L_RND: begin
          val_r  <= -LOG_W'(rnd[56:40]);
          done_r <= 1'b1;
          st_r   <= L_IDLE;
        end
        default: begin
          st_r <= L_IDLE;
        end
      endcase
    end
  end

  assign done    = done_r;
  assign log_val = val_r;

endmodule

FILE: design/grid_viterbi_layer_step.sv
// ----------------------------------------------------------------------------
// grid_viterbi_layer_step
// Viterbi layer step over a 3D grid trellis: each input word gives the
// occupancy probability of one cell; the block returns the best path cost
// and the predecessor cell from the previous layer held in cost memory.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Word contents
// in       in   in_valid / in_stall    in_prob, in_restart
// out      out  out_valid / out_stall  out_path_cost, out_pred_cell,
//                                      out_end_of_layer
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// For each word the scan reads one previous-layer cost per cycle from the
// read port of the cost memory, one per in-grid neighbour, once the
// twenty-step log unit is done.
// A word with in_restart set first runs a clearing pass over all
// MAX_X*MAX_Y*MAX_Z cells (4096 by default) of the previous layer.
// Reset is synchronous and leaves the cost memories unwritten.
// in_stall is high while a word is in progress; a finished word waits in
// the output register while the next input word is taken.
// ----------------------------------------------------------------------------
module grid_viterbi_layer_step #(
  parameter int MAX_X     = 16,
  parameter int MAX_Y     = 16,
  parameter int MAX_Z     = 16,
  parameter int MAX_REACH = 7
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [gvls_pkg::PROB_W-1:0]           in_prob,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gvls_pkg::COST_W-1:0]    out_path_cost,
  output logic [gvls_pkg::PRED_W-1:0]           out_pred_cell,
  output logic                                  out_end_of_layer,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gvls_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gvls_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import gvls_pkg::*;

  localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW    = AW + 1;
  localparam int CXW   = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int CYW   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int CZW   = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int SXW   = $clog2(MAX_X + 1);
  localparam int SYW   = $clog2(MAX_Y + 1);
  localparam int SZW   = $clog2(MAX_Z + 1);
  localparam int RW    = (MAX_REACH > 0) ? $clog2(MAX_REACH + 1) : 1;
  localparam int MAXD  = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                         : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);
  localparam int KW    = $clog2(MAXD + MAX_REACH + 16) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SET1  = 3'd1;
  localparam logic [2:0] S_SET2  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [START_W-1:0] cfg_start_x_r, cfg_start_y_r, cfg_start_z_r;
  logic [REACH_W-1:0] cfg_reach_r, cfg_reach_zl_r;
  logic [SIZE_W-1:0]  cfg_size_x_r, cfg_size_y_r, cfg_size_z_r;

  logic [2:0]     state_r;
  logic           sel_r;
  logic           restart_r;
  logic [CXW-1:0] cell_x_r;
  logic [CYW-1:0] cell_y_r;
  logic [CZW-1:0] cell_z_r;
  logic [SXW-1:0] sx_r;
  logic [SYW-1:0] sy_r;
  logic [SZW-1:0] sz_r;
  logic [RW-1:0]  rr_r, rl_r;

  logic [CXW-1:0] xlo_r, xhi_r, nx_r;
  logic [CYW-1:0] ylo_r, yhi_r, ny_r;
  logic [CZW-1:0] zlo_r, zhi_r, nz_r;
  logic [IW-1:0]  p_nb_r, p_here_r, p_st_r, xz_r;
  logic           st_in_r;
  logic [AW-1:0]  here_r, st_idx_r, col_r, row_r, idx_r, clr_r;

  logic [COST_W-1:0] mem_a [CELLS];
  logic [COST_W-1:0] mem_b [CELLS];
  logic [COST_W-1:0] q_a, q_b;

  logic                     rd_v_r;
  logic [AW-1:0]            rd_a_r;
  logic                     found_r;
  logic signed [COST_W-1:0] best_r;
  logic [PRED_W-1:0]        pred_r;

  logic                     out_valid_r;
  logic signed [COST_W-1:0] out_cost_r;
  logic [PRED_W-1:0]        out_pred_r;
  logic                     out_eol_r;

  logic                    ln_done;
  logic signed [LOG_W-1:0] ln_val;

  logic [SXW-1:0] x_eff;
  logic [SYW-1:0] y_eff;
  logic [SZW-1:0] z_eff;
  logic [RW-1:0]  r_eff, rl_eff;
  logic           accept;
  logic           finish;
  logic           scanning;
  logic           clearing;
  logic [KW-1:0]  xlo, xhi, ylo, yhi, zlo, zhi;
  logic           lx, ly, lz, last;

  logic signed [COST_W-1:0] cval;
  logic signed [COST_W:0]   sum;
  logic signed [COST_W-1:0] nv;
  logic                     take;

  logic                we_a, we_b, re_a, re_b;
  logic [AW-1:0]       wa;
  logic [COST_W-1:0]   wd;

  gvls_ln u_ln (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .prob    (in_prob),
    .done    (ln_done),
    .log_val (ln_val)
  );

  always_comb begin
    if (cfg_size_x_r == '0) begin
      x_eff = SXW'(1);
    end else if (32'(cfg_size_x_r) > MAX_X) begin
      x_eff = SXW'(MAX_X);
    end else begin
      x_eff = SXW'(cfg_size_x_r);
    end
    if (cfg_size_y_r == '0) begin
      y_eff = SYW'(1);
    end else if (32'(cfg_size_y_r) > MAX_Y) begin
      y_eff = SYW'(MAX_Y);
    end else begin
      y_eff = SYW'(cfg_size_y_r);
    end
    if (cfg_size_z_r == '0) begin
      z_eff = SZW'(1);
    end else if (32'(cfg_size_z_r) > MAX_Z) begin
      z_eff = SZW'(MAX_Z);
    end else begin
      z_eff = SZW'(cfg_size_z_r);
    end
    r_eff  = (32'(cfg_reach_r) > MAX_REACH) ? RW'(MAX_REACH) : RW'(cfg_reach_r);
    rl_eff = (32'(cfg_reach_zl_r) > MAX_REACH) ? RW'(MAX_REACH) : RW'(cfg_reach_zl_r);
  end

  always_comb begin
    xlo = (KW'(cell_x_r) >= KW'(rr_r)) ? KW'(cell_x_r) - KW'(rr_r) : '0;
    ylo = (KW'(cell_y_r) >= KW'(rr_r)) ? KW'(cell_y_r) - KW'(rr_r) : '0;
    zlo = (KW'(cell_z_r) >= KW'(rl_r)) ? KW'(cell_z_r) - KW'(rl_r) : '0;
    xhi = (KW'(cell_x_r) + KW'(rr_r) >= KW'(sx_r) - KW'(1)) ? KW'(sx_r) - KW'(1)
                                                          : KW'(cell_x_r) + KW'(rr_r);
    yhi = (KW'(cell_y_r) + KW'(rr_r) >= KW'(sy_r) - KW'(1)) ? KW'(sy_r) - KW'(1)
                                                          : KW'(cell_y_r) + KW'(rr_r);
    zhi = (KW'(cell_z_r) + KW'(rr_r) >= KW'(sz_r) - KW'(1)) ? KW'(sz_r) - KW'(1)
                                                          : KW'(cell_z_r) + KW'(rr_r);
    lx   = KW'(cell_x_r) == KW'(sx_r) - KW'(1);
    ly   = KW'(cell_y_r) == KW'(sy_r) - KW'(1);
    lz   = KW'(cell_z_r) == KW'(sz_r) - KW'(1);
    last = lx && ly && lz;
  end

  assign accept   = in_valid && (state_r == S_IDLE);
  assign finish   = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign scanning = (state_r == S_SCAN);
  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    cval = sel_r ? q_b : q_a;
    sum  = (COST_W + 1)'(cval) + (COST_W + 1)'(ln_val);
    nv   = (sum < (COST_W + 1)'(COST_MIN)) ? COST_MIN : sum[COST_W-1:0];
    take = rd_v_r && (cval != UNREACH) && (!found_r || (nv > best_r));
  end

  // The previous layer lives in bank b when sel_r is set, otherwise in a.
  assign re_a = scanning && !sel_r;
  assign re_b = scanning && sel_r;
  assign we_a = (clearing && !sel_r) || (finish && sel_r);
  assign we_b = (clearing && sel_r) || (finish && !sel_r);
  assign wa   = clearing ? clr_r : here_r;
  assign wd   = clearing ? ((st_in_r && (clr_r == st_idx_r)) ? '0 : UNREACH) : best_r;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa] <= wd;
    end
    if (re_a) begin
      q_a <= mem_a[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wa] <= wd;
    end
    if (re_b) begin
      q_b <= mem_b[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_x_r  <= '0;
      cfg_start_y_r  <= '0;
      cfg_start_z_r  <= '0;
      cfg_reach_r    <= 3'd1;
      cfg_reach_zl_r <= 3'd1;
      cfg_size_x_r   <= 5'd16;
      cfg_size_y_r   <= 5'd16;
      cfg_size_z_r   <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_X:     cfg_start_x_r  <= cfg_data[START_W-1:0];
        CFG_START_Y:     cfg_start_y_r  <= cfg_data[START_W-1:0];
        CFG_START_Z:     cfg_start_z_r  <= cfg_data[START_W-1:0];
        CFG_REACH:       cfg_reach_r    <= cfg_data[REACH_W-1:0];
        CFG_REACH_Z_LOW: cfg_reach_zl_r <= cfg_data[REACH_W-1:0];
        CFG_SIZE_X:      cfg_size_x_r   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Y:      cfg_size_y_r   <= cfg_data[SIZE_W-1:0];
        CFG_SIZE_Z:      cfg_size_z_r   <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= scanning;
    end
    rd_a_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      cell_x_r    <= '0;
      cell_y_r    <= '0;
      cell_z_r    <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      restart_r   <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !finish) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        found_r <= 1'b1;
        best_r  <= nv;
        pred_r  <= PRED_W'(IW'(rd_a_r) + IW'(1));
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            sx_r      <= x_eff;
            sy_r      <= y_eff;
            sz_r      <= z_eff;
            rr_r      <= r_eff;
            rl_r      <= rl_eff;
            restart_r <= in_restart;
            found_r   <= 1'b0;
            best_r    <= UNREACH;
            pred_r    <= '0;
            if (in_restart || (KW'(cell_x_r) >= KW'(x_eff))) begin
              cell_x_r <= '0;
            end
            if (in_restart || (KW'(cell_y_r) >= KW'(y_eff))) begin
              cell_y_r <= '0;
            end
            if (in_restart || (KW'(cell_z_r) >= KW'(z_eff))) begin
              cell_z_r <= '0;
            end
            state_r <= S_SET1;
          end
        end
        S_SET1: begin
          xlo_r    <= CXW'(xlo);
          xhi_r    <= CXW'(xhi);
          ylo_r    <= CYW'(ylo);
          yhi_r    <= CYW'(yhi);
          zlo_r    <= CZW'(zlo);
          zhi_r    <= CZW'(zhi);
          p_nb_r   <= IW'(ylo) * IW'(sx_r);
          p_here_r <= IW'(cell_y_r) * IW'(sx_r);
          p_st_r   <= IW'(cfg_start_y_r) * IW'(sx_r);
          xz_r     <= IW'(sx_r) * IW'(sz_r);
          st_in_r  <= (KW'(cfg_start_x_r) < KW'(sx_r)) &&
                      (KW'(cfg_start_y_r) < KW'(sy_r)) &&
                      (KW'(cfg_start_z_r) < KW'(sz_r));
          state_r  <= S_SET2;
        end
        S_SET2: begin
          col_r    <= AW'((IW'(xlo_r) + p_nb_r) * IW'(sz_r) + IW'(zlo_r));
          row_r    <= AW'((IW'(xlo_r) + p_nb_r) * IW'(sz_r) + IW'(zlo_r));
          idx_r    <= AW'((IW'(xlo_r) + p_nb_r) * IW'(sz_r) + IW'(zlo_r));
          here_r   <= AW'((IW'(cell_x_r) + p_here_r) * IW'(sz_r) + IW'(cell_z_r));
          st_idx_r <= AW'((IW'(cfg_start_x_r) + p_st_r) * IW'(sz_r) +
                          IW'(cfg_start_z_r));
          nx_r     <= xlo_r;
          ny_r     <= ylo_r;
          nz_r     <= zlo_r;
          clr_r    <= '0;
          state_r  <= restart_r ? S_CLEAR : S_WAIT;
        end
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CELLS - 1)) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (ln_done) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (nz_r != zhi_r) begin
            nz_r  <= nz_r + CZW'(1);
            idx_r <= idx_r + AW'(1);
          end else if (ny_r != yhi_r) begin
            ny_r  <= ny_r + CYW'(1);
            nz_r  <= zlo_r;
            row_r <= AW'(IW'(row_r) + xz_r);
            idx_r <= AW'(IW'(row_r) + xz_r);
          end else if (nx_r != xhi_r) begin
            nx_r  <= nx_r + CXW'(1);
            ny_r  <= ylo_r;
            nz_r  <= zlo_r;
            col_r <= AW'(IW'(col_r) + IW'(sz_r));
            row_r <= AW'(IW'(col_r) + IW'(sz_r));
            idx_r <= AW'(IW'(col_r) + IW'(sz_r));
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (finish) begin
            out_valid_r <= 1'b1;
            out_cost_r  <= best_r;
            out_pred_r  <= pred_r;
            out_eol_r   <= last;
            if (ly) begin
              cell_y_r <= '0;
              if (lx) begin
                cell_x_r <= '0;
                cell_z_r <= lz ? '0 : cell_z_r + CZW'(1);
              end else begin
                cell_x_r <= cell_x_r + CXW'(1);
              end
            end else begin
              cell_y_r <= cell_y_r + CYW'(1);
            end
            if (last) begin
              sel_r <= ~sel_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_path_cost    = out_cost_r;
  assign out_pred_cell    = out_pred_r;
  assign out_end_of_layer = out_eol_r;
  assign cfg_ready        = 1'b1;

`ifndef ASSERT_OFF
  a_bank_port: assert property (@(posedge clk) disable iff (!rst_n)
    !((re_a && we_a) || (re_b && we_b)))
    else $error("cost bank read and written in the same cycle");

  a_scan_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (KW'(nx_r) < KW'(sx_r)) && (KW'(ny_r) < KW'(sy_r)) &&
                          (KW'(nz_r) < KW'(sz_r)) && (32'(idx_r) < CELLS))
    else $error("neighbour scan left the grid");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word loaded outside the finishing state");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SET2) && restart_r |=> state_r == S_CLEAR)
    else $error("restart word skipped the clearing pass");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> (state_r == S_SCAN) || (state_r == S_DRAIN))
    else $error("compare stage active outside the scan");
`endif

endmodule
